// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pcap_lts_pkg.sv =====
// Types, constants and helpers for the capture-file timestamp parser
package pcap_lts_pkg;

  localparam logic [4:0] GLOBAL_HDR_LAST = 5'd23;
  localparam logic [4:0] RECORD_HDR_LAST = 5'd15;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } byte_t;

  typedef struct packed {
    logic [31:0] last_seconds;
    logic        record_seen;
    logic        file_big_endian;
  } result_t;

  // Input register contents handed to the parser
  typedef struct packed {
    logic  valid;
    byte_t item;
  } stage_t;

  // Big-endian magic, byte by byte
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'ha1;
      2'd1:    b = 8'hb2;
      2'd2:    b = 8'hc3;
      default: b = 8'hd4;
    endcase
    return b;
  endfunction

  // Assemble a 32-bit field one byte at a time in the file's byte order
  function automatic logic [31:0] shift_in(input logic [31:0] acc, input logic [7:0] b,
                                           input logic big);
    return big ? {acc[23:0], b} : {b, acc[31:8]};
  endfunction

endpackage

// ===== design/pcap_lts_in_reg.sv =====
// Input register stage: holds one accepted byte until the parser takes it
module pcap_lts_in_reg
  import pcap_lts_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   byte_valid,
  output logic   byte_ready,
  input  byte_t  byte_data,
  input  logic   consume,
  output stage_t stage
);

  logic load;

  assign byte_ready = !stage.valid || consume;
  assign load       = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= 1'b1;
    end else if (consume) begin
      stage.valid <= 1'b0;
    end
    if (load) begin
      stage.item <= byte_data;
    end
  end

endmodule

// ===== design/pcap_lts_parser.sv =====
// Parser state and the single-pass update for one byte
module pcap_lts_parser
  import pcap_lts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  stage_t  stage,
  input  logic    consume,
  output result_t res_next
);

  phase_t      phase, phase_next, p_phase;
  logic [4:0]  byte_index, byte_index_next, p_index;
  logic        big_endian_flag, big_endian_flag_next, p_big;
  logic        magic_match, magic_match_next, p_match;
  logic [31:0] seconds_staging, seconds_staging_next, p_secs;
  logic [31:0] length_staging, length_staging_next, p_len;
  logic [31:0] payload_left, payload_left_next, p_left;
  logic [31:0] kept_seconds, kept_seconds_next, p_kept;
  logic        have_record, have_record_next, p_have;
  logic [7:0]  b;
  logic        eos;

  assign b   = stage.item.data_byte;
  assign eos = stage.item.end_of_stream;

  always_comb begin
    p_phase = phase;
    p_index = byte_index;
    p_big   = big_endian_flag;
    p_match = magic_match;
    p_secs  = seconds_staging;
    p_len   = length_staging;
    p_left  = payload_left;
    p_kept  = kept_seconds;
    p_have  = have_record;

    case (phase)
      PH_RECORD: begin
        if (byte_index inside {[5'd0:5'd3]}) begin
          p_secs = shift_in(seconds_staging, b, big_endian_flag);
        end else if (byte_index inside {[5'd8:5'd11]}) begin
          p_len = shift_in(length_staging, b, big_endian_flag);
        end
        p_index = byte_index + 5'd1;
        if (byte_index == RECORD_HDR_LAST) begin
          p_kept  = seconds_staging;
          p_have  = 1'b1;
          p_left  = length_staging;
          p_index = '0;
          p_phase = (length_staging != '0) ? PH_PAYLOAD : PH_RECORD;
        end
      end
      PH_PAYLOAD: begin
        p_left = payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          p_phase = PH_RECORD;
          p_index = '0;
        end
      end
      default: begin
        // global header; an unused phase code behaves the same
        if (byte_index inside {[5'd0:5'd3]}) begin
          p_match = magic_match && (b == magic_byte(byte_index[1:0]));
          if (byte_index == 5'd3) begin
            p_big = p_match;
          end
        end
        p_index = byte_index + 5'd1;
        if (byte_index == GLOBAL_HDR_LAST) begin
          p_index = '0;
          p_phase = PH_RECORD;
        end
      end
    endcase

    res_next.last_seconds    = p_kept;
    res_next.record_seen     = p_have;
    res_next.file_big_endian = p_big;

    if (eos) begin
      // end of file: start over expecting a global header
      phase_next           = PH_GLOBAL;
      byte_index_next      = '0;
      big_endian_flag_next = 1'b0;
      magic_match_next     = 1'b1;
      seconds_staging_next = '0;
      length_staging_next  = '0;
      payload_left_next    = '0;
      kept_seconds_next    = '0;
      have_record_next     = 1'b0;
    end else begin
      phase_next           = p_phase;
      byte_index_next      = p_index;
      big_endian_flag_next = p_big;
      magic_match_next     = p_match;
      seconds_staging_next = p_secs;
      length_staging_next  = p_len;
      payload_left_next    = p_left;
      kept_seconds_next    = p_kept;
      have_record_next     = p_have;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_GLOBAL;
      byte_index      <= '0;
      big_endian_flag <= 1'b0;
      magic_match     <= 1'b1;
      seconds_staging <= '0;
      length_staging  <= '0;
      payload_left    <= '0;
      kept_seconds    <= '0;
      have_record     <= 1'b0;
    end else if (consume) begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      big_endian_flag <= big_endian_flag_next;
      magic_match     <= magic_match_next;
      seconds_staging <= seconds_staging_next;
      length_staging  <= length_staging_next;
      payload_left    <= payload_left_next;
      kept_seconds    <= kept_seconds_next;
      have_record     <= have_record_next;
    end
  end

endmodule

// ===== design/pcap_lts_out_reg.sv =====
// Result register: holds one result until the downstream side takes it
module pcap_lts_out_reg
  import pcap_lts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_next,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= res_next;
    end
  end

endmodule

// ===== design/pcap_last_timestamp_parser.sv =====
// Top level of the capture-file timestamp parser
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------
//  byte     | byte_valid / byte_ready     | byte_data (byte_t)
//  result   | result_valid / result_ready | result_data (result_t)
//
// One byte per cycle save for a held end-of-stream byte; a result is
// registered once its end-of-stream byte leaves the input register.
// Reset clears all parser state and both valid flags; no clearing pass.
// A stalled result holds back only an end-of-stream byte waiting behind
// it; other bytes keep flowing through the parser.
module pcap_last_timestamp_parser
  import pcap_lts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_valid,
  output logic    byte_ready,
  input  byte_t   byte_data,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result_data
);

  stage_t  stage;
  result_t res_next;
  logic    consume;

  // hold an end-of-stream byte while the result register is occupied and stalled
  assign consume = stage.valid &&
                   !(stage.item.end_of_stream && result_valid && !result_ready);

  pcap_lts_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .consume    (consume),
    .stage      (stage)
  );

  pcap_lts_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .consume  (consume),
    .res_next (res_next)
  );

  pcap_lts_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (consume && stage.item.end_of_stream),
    .res_next     (res_next),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

endmodule

// ===== design/pcap_lts_checker.sv =====
// Port-level checker for the timestamp parser and its bind
`include "assert_macros.svh"

module pcap_lts_checker
  import pcap_lts_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    byte_valid,
  input logic    byte_ready,
  input byte_t   byte_data,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result_data
);

  `ASSERT_CLK(a_result_held, clk, rst, result_valid && !result_ready |=> result_valid, "result transaction dropped while stalled")
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid, "result valid after reset")
  `ASSERT_CLK(a_no_record_zero, clk, rst, result_valid && !result_data.record_seen |-> result_data.last_seconds == 32'd0, "seconds reported without a record")
  `ASSERT_CLK(a_result_cause, clk, rst, $rose(result_valid) |-> $past(byte_valid && byte_ready && byte_data.end_of_stream, 2), "result without an end-of-stream transaction")

endmodule

bind pcap_last_timestamp_parser pcap_lts_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .byte_data    (byte_data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);

// ===== sim/pcap_last_timestamp_parser_test.sv =====
// Capture-file timestamp parser bench: directed table, result hold-off, random capture files
module pcap_last_timestamp_parser_test;
  import pcap_lts_pkg::*;

  localparam logic [31:0] BE_MAGIC = 32'ha1b2c3d4;
  localparam logic [4:0] GLOBAL_HDR_BYTES = 5'd24;
  localparam logic [4:0] RECORD_HDR_BYTES = 5'd16;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1400;
  localparam int CALM_AFTER = 1150;
  localparam int MIN_FILES = 20;
  localparam int SETTLE_CYCLES = 10;
  localparam int N_DIRECTED = 17;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  idx;
    logic        big;
    logic        magic_ok;
    logic [31:0] secs;
    logic [31:0] len;
    logic [31:0] left;
    logic [31:0] kept;
    logic        seen;
  } parser_model_t;

  localparam parser_model_t MODEL_AT_RESET =
    '{PH_GLOBAL, 5'd0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0};

  typedef struct packed {
    logic [7:0] b;
    logic       eos;
    logic       fixed;
    result_t    res;
  } step_row_t;

  localparam step_row_t DIRECTED[N_DIRECTED] = '{
    // single-byte files at both ends of the byte range
    '{8'hff, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}},
    '{8'h00, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}},
    // global header cut before the fourth magic byte
    '{8'ha1, 1'b0, 1'b0, '0},
    '{8'hb2, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}},
    // big-endian magic, file ends on its last byte
    '{8'ha1, 1'b0, 1'b0, '0},
    '{8'hb2, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b0, 1'b0, '0},
    '{8'hd4, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b1}},
    // last magic byte one off
    '{8'ha1, 1'b0, 1'b0, '0},
    '{8'hb2, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b0, 1'b0, '0},
    '{8'hd5, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}},
    // little-endian magic
    '{8'hd4, 1'b0, 1'b0, '0},
    '{8'hc3, 1'b0, 1'b0, '0},
    '{8'hb2, 1'b0, 1'b0, '0},
    '{8'ha1, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0}}
  };

  logic    clk;
  logic    rst = 1'b1;
  logic    byte_valid = 1'b0;
  logic    byte_ready;
  byte_t   byte_data = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result_data;

  parser_model_t parser = MODEL_AT_RESET;
  result_t       pending_reports[$];
  logic [7:0]    capture[$];
  int            bytes_sent = 0;
  int            fail_count = 0;
  int            idle_cycles = 0;
  bit            calm = 1'b0;
  bit            hold_request = 1'b0;

  pcap_last_timestamp_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] gather(input logic [31:0] acc, input logic [7:0] b,
                                         input logic big);
    return big ? {acc[23:0], b} : {b, acc[31:8]};
  endfunction

  // Advance the parser by one byte; report on an end-of-stream byte
  task automatic predict_report(input byte_t it, output bit fired, output result_t rpt);
    logic [7:0] b;
    b = it.data_byte;
    fired = 1'b0;
    rpt = '0;
    case (parser.phase)
      PH_RECORD: begin
        if (parser.idx < 5'd4)
          parser.secs = gather(parser.secs, b, parser.big);
        else if (parser.idx >= 5'd8 && parser.idx < 5'd12)
          parser.len = gather(parser.len, b, parser.big);
        parser.idx = parser.idx + 5'd1;
        if (parser.idx >= RECORD_HDR_BYTES) begin
          parser.kept = parser.secs;
          parser.seen = 1'b1;
          parser.left = parser.len;
          parser.idx = 5'd0;
          parser.phase = (parser.len != 32'd0) ? PH_PAYLOAD : PH_RECORD;
        end
      end
      PH_PAYLOAD: begin
        parser.left = parser.left - 32'd1;
        if (parser.left == 32'd0) begin
          parser.phase = PH_RECORD;
          parser.idx = 5'd0;
        end
      end
      default: begin
        if (parser.idx < 5'd4) begin
          if (b != BE_MAGIC[8 * (3 - parser.idx[1:0]) +: 8])
            parser.magic_ok = 1'b0;
          if (parser.idx == 5'd3)
            parser.big = parser.magic_ok;
        end
        parser.idx = parser.idx + 5'd1;
        if (parser.idx >= GLOBAL_HDR_BYTES) begin
          parser.idx = 5'd0;
          parser.phase = PH_RECORD;
        end
      end
    endcase
    if (it.end_of_stream) begin
      fired = 1'b1;
      rpt = '{parser.kept, parser.seen, parser.big};
      parser = MODEL_AT_RESET;
    end
  endtask

  // Offer one byte, wait for the transaction, then record what it should produce
  task automatic send_byte(input logic [7:0] b, input logic eos, input logic use_fixed,
                           input result_t fixed);
    bit      fired;
    result_t rpt;
    byte_t   it;
    it = '{b, eos};
    if (!calm && $urandom_range(0, 5) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_data <= it;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    predict_report(it, fired, rpt);
    if (fired)
      pending_reports.push_back(use_fixed ? fixed : rpt);
    bytes_sent++;
  endtask

  // Hold the input idle until every expected report has come
  task automatic drain_reports();
    byte_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic put_word(input logic [31:0] w, input bit big);
    for (int k = 0; k < 4; k++)
      capture.push_back(big ? w[8 * (3 - k) +: 8] : w[8 * k +: 8]);
  endtask

  // Build one capture file: mostly well formed, some noise, some cut short
  task automatic build_capture();
    logic [31:0] magic;
    logic [31:0] secs;
    logic [31:0] len;
    bit          big;
    bit          huge;
    int          sel;
    int          n;
    capture.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 40)) capture.push_back(8'($urandom_range(0, 255)));
      return;
    end
    sel = $urandom_range(0, 9);
    big = 1'b1;
    if (sel < 5)
      magic = BE_MAGIC;
    else if (sel < 8)
      magic = BE_MAGIC;
    else if (sel < 9)
      magic = BE_MAGIC ^ (32'd1 << $urandom_range(0, 31));
    else
      magic = $urandom;
    if (sel >= 5 && sel < 8) begin
      put_word(magic, 1'b0);
      big = 1'b0;
    end else begin
      put_word(magic, 1'b1);
      big = (magic == BE_MAGIC);
    end
    repeat (20) capture.push_back(8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) begin
      sel = $urandom_range(0, 7);
      secs = (sel == 0) ? 32'd0 : (sel == 1) ? '1 : $urandom;
      sel = $urandom_range(0, 9);
      huge = (sel == 9);
      len = (sel < 2) ? 32'd0 : huge ? ($urandom | 32'h0001_0000) : $urandom_range(1, 6);
      put_word(secs, big);
      put_word($urandom, big);
      put_word(len, big);
      put_word($urandom, big);
      n = huge ? $urandom_range(0, 8) : len;
      repeat (n) capture.push_back(8'($urandom_range(0, 255)));
      if (huge)
        break;
    end
    // cut anywhere: global header, record header or payload
    if ($urandom_range(0, 4) == 0 && capture.size() > 1)
      repeat ($urandom_range(1, capture.size() - 1)) void'(capture.pop_back());
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0)
        stall_left--;
      else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 9);
      result_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : check_reports
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected result: last_seconds %h record_seen %b file_big_endian %b",
               result_data.last_seconds, result_data.record_seen,
               result_data.file_big_endian);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (result_data.last_seconds !== want.last_seconds) begin
          $error("last_seconds: expected %h, actual %h", want.last_seconds,
                 result_data.last_seconds);
          fail_count++;
        end
        if (result_data.record_seen !== want.record_seen) begin
          $error("record_seen: expected %b, actual %b", want.record_seen,
                 result_data.record_seen);
          fail_count++;
        end
        if (result_data.file_big_endian !== want.file_big_endian) begin
          $error("file_big_endian: expected %b, actual %b", want.file_big_endian,
                 result_data.file_big_endian);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int random_files;
    random_files = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED[i].b, DIRECTED[i].eos, DIRECTED[i].fixed, DIRECTED[i].res);
    drain_reports();

    // hold off the result side while end-of-stream bytes keep coming
    hold_request = 1'b1;
    repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    drain_reports();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES || random_files < MIN_FILES) begin
      if (bytes_sent >= CALM_AFTER)
        calm = 1'b1;
      build_capture();
      foreach (capture[k])
        send_byte(capture[k], k == capture.size() - 1, 1'b0, '0);
      random_files++;
    end
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/pcap_lts_pkg.sv
design/pcap_lts_in_reg.sv
design/pcap_lts_parser.sv
design/pcap_lts_out_reg.sv
design/pcap_last_timestamp_parser.sv
design/pcap_lts_checker.sv
sim/pcap_last_timestamp_parser_test.sv
